FILE: hdl/seven_segment_scan_driver_defines.svh
// Assertion macros shared by the seven-segment scan driver modules.
// No dependencies; the files that check their own logic include this header.
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_DEFINES_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_DEFINES_SVH
`ifndef SYNTH
// Whenever cond holds at a clock edge, conseq must hold at the same edge.
`define SSD_ASSERT_IMP(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);
// Whenever cond holds at a clock edge, conseq must hold at the next edge.
`define SSD_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);
`else
`define SSD_ASSERT_IMP(label, clk, rst, cond, conseq, msg)
`define SSD_ASSERT_NEXT(label, clk, rst, cond, conseq, msg)
`endif
`endif

FILE: hdl/ssd_pkg.sv
// Types, constants and small lookup functions of the seven-segment scan driver.
// No dependencies; every module of the block imports this package.
`default_nettype none

package ssd_pkg;

   localparam int VALUE_BITS = 16;
   localparam int WORD_BITS  = 16;

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [WORD_BITS-1:0]  word_type;

   // Which decimal digit is shown: scan position minus one.
   typedef enum logic [1:0] {
      SEL_THOUSANDS = 2'd0,
      SEL_HUNDREDS  = 2'd1,
      SEL_TENS      = 2'd2,
      SEL_ONES      = 2'd3
   } digit_sel_type;

   // One finished 16-bit frame moving between the queue and its neighbors.
   typedef struct packed {
      logic     valid;
      word_type word;
   } frame_type;

   localparam logic [2:0] POS_FIRST = 3'd1;
   localparam logic [2:0] POS_LAST  = 3'd4;

   localparam logic [7:0] SEG_DP_ON_MASK = 8'h7F;
   localparam logic [7:0] SEG_DP_OFF_BIT = 8'h80;
   localparam logic [7:0] ENABLE_FIRST   = 8'h08;

   // q / 10 == (q * DIV10_K) >> DIV10_SHIFT for every 16-bit q.
   localparam logic [15:0] DIV10_K     = 16'd52429;
   localparam int          DIV10_SHIFT = 19;

   // Reciprocal multiplier for v / 1000, v / 100, v / 10 and v / 1, exact for 16-bit v.
   function automatic logic [17:0] recip_k(input digit_sel_type sel);
      logic [17:0] k;
      case (sel)
         SEL_THOUSANDS: k = 18'd67109;
         SEL_HUNDREDS:  k = 18'd167773;
         SEL_TENS:      k = 18'd52429;
         SEL_ONES:      k = 18'd1;
         default:       k = 18'd1;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] recip_shift(input digit_sel_type sel);
      logic [4:0] s;
      case (sel)
         SEL_THOUSANDS: s = 5'd26;
         SEL_HUNDREDS:  s = 5'd24;
         SEL_TENS:      s = 5'd19;
         SEL_ONES:      s = 5'd0;
         default:       s = 5'd0;
      endcase
      return s;
   endfunction

   // Active-low segment patterns, decimal point off.
   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] c;
      case (digit)
         4'd0:    c = 8'hC0;
         4'd1:    c = 8'hF9;
         4'd2:    c = 8'hA4;
         4'd3:    c = 8'hB0;
         4'd4:    c = 8'h99;
         4'd5:    c = 8'h92;
         4'd6:    c = 8'h82;
         4'd7:    c = 8'hF8;
         4'd8:    c = 8'h80;
         4'd9:    c = 8'h90;
         default: c = 8'hC0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/seven_segment_scan_driver.sv
// Top level of the seven-segment scan driver: front end, frame queue and serializer.
// Depends on ssd_pkg, ssd_front, ssd_queue and ssd_serializer.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_push / req_full  req_time_value[15:0]
//   rsp_      out        rsp_pop / rsp_empty  rsp_serial_bit, rsp_latch_after
//
// Every accepted tick yields sixteen beats: the segment byte MSB first, then the
// enable byte MSB first; rsp_latch_after is high on the sixteenth beat only.
// The serializer moves one beat per cycle while the consumer pops every cycle, and it
// reloads on the pop of a tick's last beat, so consecutive ticks stream without a gap. The
// first beat of a tick passes through the three front stages, the queue and the
// serializer's shift register. Reset is synchronous and puts the scan at the first
// digit. While the consumer stalls, the front keeps accepting until its three stages
// and the two-entry queue are full, and then raises req_full.
`default_nettype none

module seven_segment_scan_driver (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire ssd_pkg::value_type req_time_value,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic                    rsp_serial_bit,
   output logic                    rsp_latch_after
);
   import ssd_pkg::*;

   // Frames leave the front end, wait in the queue and are taken by the serializer.
   frame_type front_frame;
   frame_type queue_frame;
   logic      queue_full;
   logic      queue_take;

   // The front end picks the digit for the current position and encodes it.
   ssd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_time_value (req_time_value),
      .frame_full     (queue_full),
      .frame_out      (front_frame)
   );

   // The queue lets the front keep working while a frame is still shifting out.
   ssd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_frame (front_frame),
      .full     (queue_full),
      .rd_frame (queue_frame),
      .rd_take  (queue_take)
   );

   // The serializer reloads on the same edge that pops the last beat of a frame,
   // so consecutive frames stream without a gap.
   ssd_serializer u_serializer (
      .clock           (clock),
      .reset           (reset),
      .rd_frame        (queue_frame),
      .rd_take         (queue_take),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_serial_bit  (rsp_serial_bit),
      .rsp_latch_after (rsp_latch_after)
   );

endmodule

`default_nettype wire

FILE: hdl/ssd_front.sv
// Front end: accepts scan ticks, tracks the scan position and builds the 16-bit frame.
// Depends on ssd_pkg.
`default_nettype none

module ssd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire ssd_pkg::value_type req_time_value,
   input  wire logic               frame_full,
   output ssd_pkg::frame_type      frame_out
);
   import ssd_pkg::*;

   logic [2:0]    scan_position_ff, scan_position_in;
   logic [2:0]    pos_clamped;
   digit_sel_type sel_now;
   logic          accept;

   // Stage 0: captured tick.
   logic          vld0_ff, vld0_in;
   value_type     v0_ff;
   digit_sel_type sel0_ff;
   // Stage 1: value divided by the place weight.
   logic          vld1_ff, vld1_in;
   logic [15:0]   q1_ff;
   digit_sel_type sel1_ff;
   // Stage 2: the selected decimal digit.
   logic          vld2_ff, vld2_in;
   logic [3:0]    digit2_ff;
   digit_sel_type sel2_ff;

   logic          load1, load2, load0;
   logic [33:0]   prod1;
   logic [31:0]   prod2;
   logic [12:0]   tenth;
   logic [15:0]   tens;
   logic [7:0]    seg_raw, seg, en;

   // Stage k may load when it is empty or its content moves on this cycle.
   assign load2 = !vld2_ff || !frame_full;
   assign load1 = !vld1_ff || load2;
   assign load0 = !vld0_ff || load1;

   assign req_full = !load0;
   assign accept   = req_push && load0;

   // An out-of-range position is treated as the first one.
   assign pos_clamped = (scan_position_ff >= POS_FIRST && scan_position_ff <= POS_LAST) ?
                        scan_position_ff : POS_FIRST;
   assign sel_now     = digit_sel_type'(2'(pos_clamped - POS_FIRST));
   assign scan_position_in = accept ?
                             ((pos_clamped == POS_LAST) ? POS_FIRST : pos_clamped + 3'd1) :
                             scan_position_ff;

   assign vld0_in = load0 ? req_push : vld0_ff;
   assign vld1_in = load1 ? vld0_ff  : vld1_ff;
   assign vld2_in = load2 ? vld1_ff  : vld2_ff;

   assign prod1 = 34'(v0_ff) * 34'(recip_k(sel0_ff));
   assign prod2 = 32'(q1_ff) * 32'(DIV10_K);
   assign tenth = 13'(prod2 >> DIV10_SHIFT);
   assign tens  = 16'({tenth, 3'b000}) + 16'({tenth, 1'b0});

   assign seg_raw = seg_code(digit2_ff);
   assign seg     = (sel2_ff == SEL_THOUSANDS) ? (seg_raw & SEG_DP_ON_MASK) :
                                                 (seg_raw | SEG_DP_OFF_BIT);
   assign en      = ENABLE_FIRST >> sel2_ff;

   assign frame_out.valid = vld2_ff;
   assign frame_out.word  = {seg, en};

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_position_ff <= POS_FIRST;
         vld0_ff          <= 1'b0;
         vld1_ff          <= 1'b0;
         vld2_ff          <= 1'b0;
      end else begin
         scan_position_ff <= scan_position_in;
         vld0_ff          <= vld0_in;
         vld1_ff          <= vld1_in;
         vld2_ff          <= vld2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         v0_ff   <= req_time_value;
         sel0_ff <= sel_now;
      end
      if (load1) begin
         q1_ff   <= 16'(prod1 >> recip_shift(sel0_ff));
         sel1_ff <= sel0_ff;
      end
      if (load2) begin
         digit2_ff <= 4'(q1_ff - tens);
         sel2_ff   <= sel1_ff;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/ssd_queue.sv
// Two-entry frame queue between the front end and the serializer.
// Depends on ssd_pkg and the assertion macro header.
`default_nettype none
`include "seven_segment_scan_driver_defines.svh"

module ssd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ssd_pkg::frame_type wr_frame,
   output logic                    full,
   output ssd_pkg::frame_type      rd_frame,
   input  wire logic               rd_take
);
   import ssd_pkg::*;

   word_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       wr, rd;

   assign full  = (cnt_ff == 2'd2);
   assign wr    = wr_frame.valid && !full;
   assign rd    = rd_take && (cnt_ff != 2'd0);

   assign rd_frame.valid = (cnt_ff != 2'd0);
   assign rd_frame.word  = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = wr ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = rd ? !rd_ptr_ff : rd_ptr_ff;
   assign cnt_in    = cnt_ff + 2'(wr) - 2'(rd);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wr_ptr_ff] <= wr_frame.word;
      end
   end

   `SSD_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, cnt_ff != 2'd3, "queue count out of range")
   `SSD_ASSERT_IMP(a_ptrs_full, clock, reset, full, wr_ptr_ff == rd_ptr_ff,
                   "pointers disagree with full")

endmodule

`default_nettype wire

FILE: hdl/ssd_serializer.sv
// Back end: shifts each frame out one bit per beat, MSB first, flagging the last bit.
// Depends on ssd_pkg and the assertion macro header.
`default_nettype none
`include "seven_segment_scan_driver_defines.svh"

module ssd_serializer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ssd_pkg::frame_type rd_frame,
   output logic                    rd_take,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic                    rsp_serial_bit,
   output logic                    rsp_latch_after
);
   import ssd_pkg::*;

   logic       busy_ff, busy_in;
   word_type   shift_ff, shift_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       pop_ok, last;

   assign pop_ok  = rsp_pop && busy_ff;
   assign last    = (cnt_ff == 4'hF);
   assign rd_take = rd_frame.valid && (!busy_ff || (pop_ok && last));

   assign rsp_empty       = !busy_ff;
   assign rsp_serial_bit  = shift_ff[WORD_BITS-1];
   assign rsp_latch_after = last;

   always_comb begin
      busy_in  = busy_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      if (rd_take) begin
         busy_in  = 1'b1;
         shift_in = rd_frame.word;
         cnt_in   = 4'd0;
      end else if (pop_ok) begin
         if (last) begin
            busy_in = 1'b0;
            cnt_in  = 4'd0;
         end else begin
            shift_in = {shift_ff[WORD_BITS-2:0], 1'b0};
            cnt_in   = cnt_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   `SSD_ASSERT_IMP(a_idle_cnt, clock, reset, !busy_ff, cnt_ff == 4'd0, "bit count moved while idle")
   `SSD_ASSERT_NEXT(a_mid_frame, clock, reset, pop_ok && !last, busy_ff, "frame ended early")
   `SSD_ASSERT_NEXT(a_drain, clock, reset, pop_ok && last && !rd_frame.valid, !busy_ff,
                    "serializer busy with no frame")

endmodule

`default_nettype wire

FILE: sim/tb_seven_segment_scan_driver.sv
`timescale 1ns / 100ps
// Self-checking testbench for seven_segment_scan_driver: scan ticks in, serial beats out.
// Depends on ssd_pkg (value type of the tick port) and the seven_segment_scan_driver RTL.

module tb_seven_segment_scan_driver;

   // Run shape. The random phase carries most of the ticks; the other phases add
   // directed values, a long consumer hold-off and a gap-free stream.
   localparam int RANDOM_TICKS    = 380;
   localparam int PRESSURE_TICKS  = 40;
   localparam int STEADY_TICKS    = 60;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int SETTLE_CYCLES   = 32;

   // Display encoding as the predictor sees it: the decimal point is bit 7 of the
   // segment byte, active low, and the enable byte walks right from bit 3.
   localparam logic [7:0] DP_LIT_MASK  = 8'h7F;
   localparam logic [7:0] DP_DARK_BIT  = 8'h80;
   localparam logic [7:0] FIRST_ENABLE = 8'h08;
   localparam int         FIRST_POS    = 1;
   localparam int         LAST_POS     = 4;
   localparam int         BEATS_PER_TICK = 16;

   // One serial beat as it leaves the block.
   typedef struct packed {
      logic serial_bit;
      logic latch_after;
   } beat_type;

   // Every input is known from time zero; reset is high until the start sequence drops it.
   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_push       = 1'b0;
   logic               req_full;
   ssd_pkg::value_type req_time_value = '0;
   logic               rsp_empty;
   logic               rsp_pop        = 1'b0;
   logic               rsp_serial_bit;
   logic               rsp_latch_after;

   // Predicted beats in the order the block must deliver them.
   beat_type expected_beats[$];

   // Scan position as the predictor tracks it, and what the run has seen so far.
   int scan_pos       = FIRST_POS;
   int ticks_sent     = 0;
   int beats_checked  = 0;
   int mismatch_count = 0;
   int full_stalls    = 0;
   int pos_hits[4]    = '{0, 0, 0, 0};

   // Consumer controls. The stimulus process posts a hold-off length; the consumer
   // process picks it up and counts it down itself.
   int hold_request  = 0;
   int hold_left     = 0;
   bit rx_steady     = 1'b0;
   int rx_run_left   = 0;
   int rx_stall_left = 0;

   seven_segment_scan_driver dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_time_value  (req_time_value),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_serial_bit  (rsp_serial_bit),
      .rsp_latch_after (rsp_latch_after)
   );

   always #4 clock = ~clock;

   // Hard stop in case the block hangs; the slowest correct run is far shorter.
   initial begin
      #2_000_000;
      $display("tb_seven_segment_scan_driver: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   // Active-low segment pattern of one decimal digit with the decimal point dark.
   function automatic logic [7:0] glyph_of(input int digit);
      logic [7:0] g;
      case (digit)
         0:       g = 8'hC0;
         1:       g = 8'hF9;
         2:       g = 8'hA4;
         3:       g = 8'hB0;
         4:       g = 8'h99;
         5:       g = 8'h92;
         6:       g = 8'h82;
         7:       g = 8'hF8;
         8:       g = 8'h80;
         default: g = 8'h90;
      endcase
      return g;
   endfunction

   // The sixteen-bit frame shifted out for one tick: segment byte over enable byte.
   // Position 1 shows the thousands digit with the decimal point lit; positions 2 to 4
   // show hundreds, tens and ones. Values above 9999 keep only their low four digits.
   function automatic logic [15:0] frame_for(input ssd_pkg::value_type v, input int pos);
      int         value;
      int         digit;
      logic [7:0] seg;
      logic [7:0] en;
      value = int'(v);
      case (pos)
         2:       digit = (value / 100) % 10;
         3:       digit = (value / 10) % 10;
         4:       digit = value % 10;
         default: digit = (value / 1000) % 10;
      endcase
      seg = glyph_of(digit);
      if (pos == FIRST_POS) begin
         seg = seg & DP_LIT_MASK;
      end else begin
         seg = seg | DP_DARK_BIT;
      end
      en = FIRST_ENABLE >> (pos - 1);
      return {seg, en};
   endfunction

   // Queues the beats of one accepted tick and advances the scan, wrapping 4 to 1.
   // A position outside 1..4 cannot arise; it would be shown as position 1.
   task automatic predict_tick(input ssd_pkg::value_type v);
      int          pos;
      logic [15:0] frame;
      beat_type    b;
      pos = scan_pos;
      if (pos < FIRST_POS || pos > LAST_POS) begin
         pos = FIRST_POS;
      end
      frame = frame_for(v, pos);
      for (int k = 0; k < BEATS_PER_TICK; k++) begin
         b.serial_bit  = frame[BEATS_PER_TICK - 1 - k];
         b.latch_after = (k == BEATS_PER_TICK - 1);
         expected_beats.push_back(b);
      end
      pos_hits[pos - 1]++;
      ticks_sent++;
      scan_pos = (pos >= LAST_POS) ? FIRST_POS : pos + 1;
   endtask

   // ---------------------------------------------------------------------------
   // Producer side
   // ---------------------------------------------------------------------------

   // Offers one tick and holds it until the block takes it. req_push stays high on
   // return so that back-to-back calls form a burst without a dropped cycle.
   task automatic send_tick(input ssd_pkg::value_type v);
      req_push       <= 1'b1;
      req_time_value <= v;
      @(posedge clock);
      while (req_full) begin
         full_stalls++;
         @(posedge clock);
      end
      predict_tick(v);
   endtask

   // Idles the producer for some cycles with noise on the data port.
   task automatic pause_sender(input int cycles);
      req_push       <= 1'b0;
      req_time_value <= ssd_pkg::value_type'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   // Waits until every predicted beat has been delivered, or flags a hang.
   task automatic wait_drained();
      int cycles;
      cycles = 0;
      while (expected_beats.size() != 0 && cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      if (expected_beats.size() != 0) begin
         $error("block stopped delivering: %0d beats still expected", expected_beats.size());
         mismatch_count++;
      end
   endtask

   // Random tick value: mostly the full range, with a lean toward four-digit values,
   // the corners and repeated digits so every glyph turns up at every position.
   function automatic ssd_pkg::value_type random_value();
      int pick;
      int d;
      pick = $urandom_range(0, 9);
      d    = $urandom_range(0, 9);
      case (pick)
         6, 7:    return ssd_pkg::value_type'($urandom_range(0, 9999));
         8: begin
            case ($urandom_range(0, 4))
               0:       return 16'd0;
               1:       return 16'd9999;
               2:       return 16'd10000;
               3:       return 16'd59999;
               default: return 16'd65535;
            endcase
         end
         9:       return ssd_pkg::value_type'(d * 1111);
         default: return ssd_pkg::value_type'($urandom_range(0, 65535));
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Consumer side and checking
   // ---------------------------------------------------------------------------

   // Compares one delivered beat with the oldest prediction.
   task automatic check_beat();
      beat_type want;
      if (expected_beats.size() == 0) begin
         $error("unexpected beat: serial_bit=%0b latch_after=%0b",
                rsp_serial_bit, rsp_latch_after);
         mismatch_count++;
      end else begin
         want = expected_beats.pop_front();
         beats_checked++;
         if (rsp_serial_bit !== want.serial_bit) begin
            $error("serial_bit mismatch: expected %0b, actual %0b",
                   want.serial_bit, rsp_serial_bit);
            mismatch_count++;
         end
         if (rsp_latch_after !== want.latch_after) begin
            $error("latch_after mismatch: expected %0b, actual %0b",
                   want.latch_after, rsp_latch_after);
            mismatch_count++;
         end
      end
   endtask

   // The consumer checks every beat taken at this edge and then decides whether to
   // pop at the next one. A posted hold-off wins over everything else. Outside a
   // hold-off the consumer either pops every cycle or alternates random runs of
   // pops and stalls, so stalls fall on every beat of a frame.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            check_beat();
         end
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (rx_steady) begin
            rsp_pop <= 1'b1;
         end else if (rx_run_left != 0) begin
            rx_run_left--;
            rsp_pop <= 1'b1;
         end else if (rx_stall_left != 0) begin
            rx_stall_left--;
            rsp_pop <= 1'b0;
         end else begin
            rx_run_left   = $urandom_range(0, 24);
            rx_stall_left = $urandom_range(1, 7);
            rsp_pop <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Field extremes, every glyph from 0 to 9, bit patterns on the value, values
   // above 9999, and several wraps of the scan position.
   task automatic test_directed_values();
      ssd_pkg::value_type vals[22];
      vals = '{16'd0, 16'd0, 16'd0, 16'd0,
               16'd65535, 16'd65535, 16'd65535, 16'd65535,
               16'd9999, 16'd8888, 16'd7777, 16'd6666, 16'd5555,
               16'd4444, 16'd3333, 16'd2222, 16'd1111,
               16'd10000, 16'hAAAA, 16'h5555, 16'd12345, 16'd59999};
      foreach (vals[i]) begin
         send_tick(vals[i]);
         if ($urandom_range(0, 3) == 0) begin
            pause_sender($urandom_range(1, 5));
         end
      end
      pause_sender(1);
      wait_drained();
   endtask

   // Random values in bursts of random length separated by random gaps.
   task automatic test_random_bursts();
      int burst_left;
      burst_left = $urandom_range(1, 12);
      for (int i = 0; i < RANDOM_TICKS; i++) begin
         if (burst_left == 0) begin
            pause_sender($urandom_range(1, 20));
            burst_left = $urandom_range(1, 12);
         end
         send_tick(random_value());
         burst_left--;
      end
      pause_sender(1);
      wait_drained();
   endtask

   // The consumer holds off for a long stretch while the producer keeps offering
   // ticks, so the block fills and raises req_full. The producer then stops until
   // every beat has come out.
   task automatic test_backpressure();
      hold_request = HOLD_OFF_CYCLES;
      for (int i = 0; i < PRESSURE_TICKS; i++) begin
         send_tick(random_value());
      end
      pause_sender(1);
      wait_drained();
   endtask

   // No idling on either side: ticks back to back and a pop every cycle, which runs
   // the block at its full rate.
   task automatic test_steady_stream();
      rx_steady = 1'b1;
      for (int i = 0; i < STEADY_TICKS; i++) begin
         send_tick(random_value());
      end
      pause_sender(1);
      wait_drained();
      rx_steady = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_values();
      test_random_bursts();
      test_backpressure();
      test_steady_stream();

      // Give the block time to show any stray beat after the last expected one.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_beats.size() != 0) begin
         $error("%0d beats never delivered", expected_beats.size());
         mismatch_count++;
      end

      $display("Sent %0d ticks and checked %0d beats;", ticks_sent, beats_checked);
      $display("scan positions 1-4 shown %0d/%0d/%0d/%0d times.",
               pos_hits[0], pos_hits[1], pos_hits[2], pos_hits[3]);
      $display("The producer waited on a full block for %0d cycles; %0d mismatches found.",
               full_stalls, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb_seven_segment_scan_driver: done, clean");
      end else begin
         $display("tb_seven_segment_scan_driver: done, errors");
      end
      $finish;
   end

endmodule
